// ----- hdl/clr_pkg.sv -----
// clr_pkg: types and constants for the clipped line rasterizer
// used by clipped_line_rasterizer; no dependencies
`timescale 1ns / 1ps

package clr_pkg;

  localparam int COORD_W = 12;
  localparam int CUR_W   = 13;
  localparam int NDY_W   = 14;
  localparam int ERR_W   = 15;
  localparam int DIM_W   = 13;
  localparam int COL_W   = 16;
  localparam int PIX_W   = 11;
  localparam int ADDR_W  = 22;
  localparam int CFG_W   = 12;

  typedef logic [1:0] style_t;
  localparam style_t STYLE_SOLID  = 2'd0;
  localparam style_t STYLE_DOTTED = 2'd1;
  localparam style_t STYLE_THICK  = 2'd2;

  typedef logic op_t;
  localparam op_t OP_START = 1'b0;
  localparam op_t OP_STEP  = 1'b1;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_SURFACE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_SURFACE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SURFACE_WIDTH_RST  = 12'd1280;
  localparam logic [CFG_W-1:0] SURFACE_HEIGHT_RST = 12'd800;

  localparam int DOT_BIT = 2;

  // one pending step: the point before the advance and how to emit it
  typedef struct packed {
    logic signed [CUR_W-1:0] x;
    logic signed [CUR_W-1:0] y;
    logic [COL_W-1:0]        colour;
    logic                    paint;
    logic                    done;
    logic                    thick;
  } job_t;

endpackage

// ----- hdl/clipped_line_rasterizer.sv -----
// clipped_line_rasterizer: Bresenham line walker with surface clamping and addressing
// depends on clr_pkg
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_stall): op 0 loads a line (end points, colour,
//   style) and gives no beat; op 1 steps the active line. a step while no line
//   is active is dropped.
//   result channel (out_valid / out_stall): one beat per step for solid and
//   dotted lines, four beats (2x2 block) per step for thick lines; out_last
//   marks the final beat of a step, out_line_done marks every beat of the step
//   that reached the end point.
//   config port: cfg_we writes cfg_wdata into surface width (index 0) or
//   height (index 1); write only while the block is idle.
// timing
//   a step's first beat is loaded into the step holding register and then into
//   the result register. one input beat per cycle for solid and dotted lines
//   while out_stall is low; a thick step occupies the single step holding
//   register for four result beats and frees it as the last of them loads.
//   the clamp, 13x13 address multiply and add sit between these two registers.
// reset and stall
//   synchronous active low reset drops any line and pending beats and restores
//   1280 x 800. while out_stall is high a valid result register holds and
//   in_stall rises as soon as the holding register is full.

module clipped_line_rasterizer #(
  parameter int MAX_DIM = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic signed [clr_pkg::COORD_W-1:0] in_x_start,
  input  logic signed [clr_pkg::COORD_W-1:0] in_y_start,
  input  logic signed [clr_pkg::COORD_W-1:0] in_x_end,
  input  logic signed [clr_pkg::COORD_W-1:0] in_y_end,
  input  logic [clr_pkg::COL_W-1:0]       in_pen_colour,
  input  logic [1:0]                      in_style,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clr_pkg::PIX_W-1:0]       out_pix_x,
  output logic [clr_pkg::PIX_W-1:0]       out_pix_y,
  output logic [clr_pkg::ADDR_W-1:0]      out_pix_addr,
  output logic [clr_pkg::COL_W-1:0]       out_pix_colour,
  output logic                            out_paint,
  output logic                            out_line_done,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [clr_pkg::CFG_W-1:0]       cfg_wdata
);
  import clr_pkg::*;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  // configuration
  logic [CFG_W-1:0] surf_w_r, surf_h_r;
  logic [DIM_W-1:0] eff_w, eff_h;

  // line state
  logic                    active_r, active_nxt;
  logic signed [CUR_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CUR_W-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [CUR_W-1:0]        delta_x_r, delta_x_nxt;
  logic signed [NDY_W-1:0] ndy_r, ndy_nxt;
  logic                    sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [COL_W-1:0]        colour_r, colour_nxt;
  style_t                  style_r, style_nxt;
  logic [2:0]              dash_r, dash_nxt;

  // step holding register
  logic       job_valid_r, job_valid_nxt;
  job_t       job_r, job_nxt;
  logic [1:0] job_idx_r, job_idx_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  pix_x_r, pix_y_r;
  logic [ADDR_W-1:0] addr_r;
  logic [COL_W-1:0]  ocol_r;
  logic              paint_r, done_r, last_r;

  logic in_acc, out_load, job_last, job_finish, step_go;

  // start decode
  logic signed [CUR_W-1:0] x0, y0, x1, y1, dxs;
  logic signed [NDY_W-1:0] y0w, y1w;
  logic [CUR_W-1:0]        dx_abs;
  logic signed [NDY_W-1:0] ndy_new;

  // bresenham advance
  logic                    at_end;
  logic signed [ERR_W:0]   e2;
  logic                    adv_x, adv_y;
  logic signed [ERR_W+1:0] err_sum;

  // beat datapath
  logic signed [CUR_W:0]   bx, by;
  logic [DIM_W-1:0]        cx, cy;
  logic [2*DIM_W-1:0]      prod;
  logic [2*DIM_W-1:0]      addr_full;

  always_comb begin
    eff_w = {1'b0, surf_w_r};
    if (surf_w_r == '0) begin
      eff_w = DIM_W'(1);
    end else if ({1'b0, surf_w_r} > MAX_DIM_C) begin
      eff_w = MAX_DIM_C;
    end
    eff_h = {1'b0, surf_h_r};
    if (surf_h_r == '0) begin
      eff_h = DIM_W'(1);
    end else if ({1'b0, surf_h_r} > MAX_DIM_C) begin
      eff_h = MAX_DIM_C;
    end
  end

  assign job_last   = !job_r.thick || (job_idx_r == 2'd3);
  assign out_load   = !out_valid_r || !out_stall;
  assign job_finish = job_valid_r && out_load && job_last;
  assign in_stall   = job_valid_r && !job_finish;
  assign in_acc     = in_valid && !in_stall;
  assign step_go    = in_acc && (in_op == OP_STEP) && active_r;

  always_comb begin
    x0  = CUR_W'(in_x_start);
    y0  = CUR_W'(in_y_start);
    x1  = CUR_W'(in_x_end);
    y1  = CUR_W'(in_y_end);
    dxs = x1 - x0;
    dx_abs = dxs[CUR_W-1] ? CUR_W'(-dxs) : CUR_W'(dxs);
    y0w = NDY_W'(in_y_start);
    y1w = NDY_W'(in_y_end);
    ndy_new = (y1w > y0w) ? (y0w - y1w) : (y1w - y0w);

    at_end  = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
    e2      = {err_r, 1'b0};
    adv_x   = e2 >= (ERR_W+1)'(ndy_r);
    adv_y   = e2 <= $signed({3'b000, delta_x_r});
    err_sum = (ERR_W+2)'(err_r)
            + (adv_x ? (ERR_W+2)'(ndy_r) : '0)
            + (adv_y ? $signed({4'b0000, delta_x_r}) : '0);
  end

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    delta_x_nxt = delta_x_r;
    ndy_nxt    = ndy_r;
    sx_neg_nxt = sx_neg_r;
    sy_neg_nxt = sy_neg_r;
    err_nxt    = err_r;
    colour_nxt = colour_r;
    style_nxt  = style_r;
    dash_nxt   = dash_r;

    if (in_acc && (in_op == OP_START)) begin
      active_nxt  = 1'b1;
      cur_x_nxt   = x0;
      cur_y_nxt   = y0;
      tgt_x_nxt   = x1;
      tgt_y_nxt   = y1;
      delta_x_nxt = dx_abs;
      ndy_nxt     = ndy_new;
      sx_neg_nxt  = !(x0 < x1);
      sy_neg_nxt  = !(y0 < y1);
      err_nxt     = ERR_W'($signed({2'b00, dx_abs}) + ERR_W'(ndy_new));
      colour_nxt  = in_pen_colour;
      style_nxt   = in_style;
      dash_nxt    = '0;
    end else if (step_go) begin
      if (style_r == STYLE_DOTTED) begin
        dash_nxt = dash_r + 3'd1;
      end
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = ERR_W'(err_sum);
        if (adv_x) begin
          cur_x_nxt = sx_neg_r ? cur_x_r - CUR_W'(1) : cur_x_r + CUR_W'(1);
        end
        if (adv_y) begin
          cur_y_nxt = sy_neg_r ? cur_y_r - CUR_W'(1) : cur_y_r + CUR_W'(1);
        end
      end
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    job_idx_nxt   = job_idx_r;
    if (job_valid_r && out_load) begin
      job_idx_nxt = job_idx_r + 2'd1;
    end
    if (job_finish) begin
      job_valid_nxt = 1'b0;
    end
    if (step_go) begin
      job_valid_nxt = 1'b1;
      job_idx_nxt   = 2'd0;
      job_nxt.x      = cur_x_r;
      job_nxt.y      = cur_y_r;
      job_nxt.colour = colour_r;
      job_nxt.thick  = (style_r == STYLE_THICK);
      job_nxt.paint  = (style_r == STYLE_DOTTED) ? dash_r[DOT_BIT] : 1'b1;
      job_nxt.done   = at_end;
    end
  end

  // clamp and address for the beat in the holding register
  always_comb begin
    bx = (CUR_W+1)'(job_r.x) + (job_r.thick ? (CUR_W+1)'(job_idx_r[0]) : '0);
    by = (CUR_W+1)'(job_r.y) + (job_r.thick ? (CUR_W+1)'(job_idx_r[1]) : '0);
    if (bx < 0) begin
      cx = '0;
    end else if (bx >= $signed({1'b0, eff_w})) begin
      cx = eff_w - DIM_W'(1);
    end else begin
      cx = DIM_W'(bx);
    end
    if (by < 0) begin
      cy = '0;
    end else if (by >= $signed({1'b0, eff_h})) begin
      cy = eff_h - DIM_W'(1);
    end else begin
      cy = DIM_W'(by);
    end
    prod      = cy * eff_w;
    addr_full = prod + (2*DIM_W)'(cx);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r    <= SURFACE_WIDTH_RST;
      surf_h_r    <= SURFACE_HEIGHT_RST;
      active_r    <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      delta_x_r   <= '0;
      ndy_r       <= '0;
      sx_neg_r    <= 1'b0;
      sy_neg_r    <= 1'b0;
      err_r       <= '0;
      colour_r    <= '0;
      style_r     <= STYLE_SOLID;
      dash_r      <= '0;
      job_valid_r <= 1'b0;
      job_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SURFACE_WIDTH:  surf_w_r <= cfg_wdata;
          CFG_SURFACE_HEIGHT: surf_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      active_r    <= active_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      tgt_x_r     <= tgt_x_nxt;
      tgt_y_r     <= tgt_y_nxt;
      delta_x_r   <= delta_x_nxt;
      ndy_r       <= ndy_nxt;
      sx_neg_r    <= sx_neg_nxt;
      sy_neg_r    <= sy_neg_nxt;
      err_r       <= err_nxt;
      colour_r    <= colour_nxt;
      style_r     <= style_nxt;
      dash_r      <= dash_nxt;
      job_valid_r <= job_valid_nxt;
      job_idx_r   <= job_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (out_load && job_valid_r) begin
      pix_x_r <= PIX_W'(cx);
      pix_y_r <= PIX_W'(cy);
      addr_r  <= ADDR_W'(addr_full);
      ocol_r  <= job_r.colour;
      paint_r <= job_r.paint;
      done_r  <= job_r.done;
      last_r  <= job_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pix_x      = pix_x_r;
  assign out_pix_y      = pix_y_r;
  assign out_pix_addr   = addr_r;
  assign out_pix_colour = ocol_r;
  assign out_paint      = paint_r;
  assign out_line_done  = done_r;
  assign out_last       = last_r;

  // a thick step keeps the result channel busy until its last beat
  a_thick_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |=> out_valid_r)
    else $error("beat stream of a thick step broke off before its last beat");

  // only thick steps walk the sub-beat index
  a_idx_thick: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && !job_r.thick |-> job_idx_r == 2'd0)
    else $error("sub-beat index moved on a single-beat step");

  // a step that reached the end point leaves the line inactive
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && at_end |=> !active_r)
    else $error("line still active after its end point");

  // effective surface dimensions are never zero
  a_dim_nz: assert property (@(posedge clk) disable iff (!rst_n)
    eff_w != '0 && eff_h != '0)
    else $error("effective surface dimension is zero");

  // a non-final beat in the result register implies its step is still held
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> job_valid_r)
    else $error("remaining beats of a thick step were lost");

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for clipped_line_rasterizer, with a scoreboard class that
// walks each line itself and checks every pixel beat against its own prediction
// depends on clr_pkg and clipped_line_rasterizer
`timescale 1ns / 1ps

import clr_pkg::*;

localparam int MAX_DIM = 2048;
localparam style_t STYLE_SPARE = 2'd3;

typedef struct packed {
  logic [PIX_W-1:0]  x;
  logic [PIX_W-1:0]  y;
  logic [ADDR_W-1:0] addr;
  logic [COL_W-1:0]  colour;
  logic              paint;
  logic              done;
  logic              last;
} pixel_t;

class raster_board;
  logic [CFG_W-1:0]        width_reg;
  logic [CFG_W-1:0]        height_reg;
  logic                    running;
  logic signed [CUR_W-1:0] pos_x;
  logic signed [CUR_W-1:0] pos_y;
  logic signed [CUR_W-1:0] goal_x;
  logic signed [CUR_W-1:0] goal_y;
  logic [CUR_W-1:0]        span_x;
  logic signed [NDY_W-1:0] span_ny;
  logic                    back_x;
  logic                    back_y;
  logic signed [ERR_W-1:0] err;
  logic [COL_W-1:0]        colour;
  style_t                  style;
  logic [2:0]              dots;
  pixel_t                  pending_pixels[$];
  int                      mismatches;
  int                      pixels_seen;

  function new();
    width_reg  = SURFACE_WIDTH_RST;
    height_reg = SURFACE_HEIGHT_RST;
    running    = 1'b0;
    pos_x      = '0;
    pos_y      = '0;
    goal_x     = '0;
    goal_y     = '0;
    span_x     = '0;
    span_ny    = '0;
    back_x     = 1'b0;
    back_y     = 1'b0;
    err        = '0;
    colour     = '0;
    style      = STYLE_SOLID;
    dots       = '0;
    mismatches = 0;
    pixels_seen = 0;
  endfunction

  function void set_surface(cfg_idx_t idx, logic [CFG_W-1:0] val);
    if (idx == CFG_SURFACE_WIDTH) width_reg = val;
    else height_reg = val;
  endfunction

  function int eff_dim(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function pixel_t place_pixel(int x, int y, logic paint);
    int w;
    int h;
    int cx;
    int cy;
    pixel_t p;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    cx = (x < 0) ? 0 : ((x > w - 1) ? w - 1 : x);
    cy = (y < 0) ? 0 : ((y > h - 1) ? h - 1 : y);
    p.x = PIX_W'(cx);
    p.y = PIX_W'(cy);
    p.addr = ADDR_W'(cx + cy * w);
    p.colour = colour;
    p.paint = paint;
    p.done = 1'b0;
    p.last = 1'b0;
    return p;
  endfunction

  function void note_input(op_t op, logic signed [COORD_W-1:0] xs, logic signed [COORD_W-1:0] ys,
                           logic signed [COORD_W-1:0] xe, logic signed [COORD_W-1:0] ye,
                           logic [COL_W-1:0] pen, style_t sty);
    int x0;
    int y0;
    int x1;
    int y1;
    int dx;
    int ndy;
    int e;
    int e2;
    int n;
    int k;
    logic hit;
    pixel_t blk[4];
    if (op == OP_START) begin
      x0 = xs;
      y0 = ys;
      x1 = xe;
      y1 = ye;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ndy = (y1 > y0) ? y0 - y1 : y1 - y0;
      pos_x = CUR_W'(x0);
      pos_y = CUR_W'(y0);
      goal_x = CUR_W'(x1);
      goal_y = CUR_W'(y1);
      span_x = CUR_W'(dx);
      span_ny = NDY_W'(ndy);
      back_x = !(x0 < x1);
      back_y = !(y0 < y1);
      err = ERR_W'(dx + ndy);
      colour = pen;
      style = sty;
      dots = '0;
      running = 1'b1;
      return;
    end
    if (!running) return;
    n = 1;
    if (style == STYLE_THICK) begin
      blk[0] = place_pixel(pos_x, pos_y, 1'b1);
      blk[1] = place_pixel(pos_x + 1, pos_y, 1'b1);
      blk[2] = place_pixel(pos_x, pos_y + 1, 1'b1);
      blk[3] = place_pixel(pos_x + 1, pos_y + 1, 1'b1);
      n = 4;
    end else if (style == STYLE_DOTTED) begin
      blk[0] = place_pixel(pos_x, pos_y, dots[DOT_BIT]);
      dots = dots + 3'd1;
    end else begin
      blk[0] = place_pixel(pos_x, pos_y, 1'b1);
    end
    hit = (pos_x == goal_x) && (pos_y == goal_y);
    if (hit) begin
      running = 1'b0;
    end else begin
      e = err;
      dx = span_x;
      ndy = span_ny;
      e2 = 2 * e;
      if (e2 >= ndy) begin
        e += ndy;
        pos_x = back_x ? pos_x - CUR_W'(1) : pos_x + CUR_W'(1);
      end
      if (e2 <= dx) begin
        e += dx;
        pos_y = back_y ? pos_y - CUR_W'(1) : pos_y + CUR_W'(1);
      end
      err = ERR_W'(e);
    end
    for (k = 0; k < n; k++) begin
      blk[k].done = hit;
      blk[k].last = (k == n - 1);
      pending_pixels.push_back(blk[k]);
    end
  endfunction

  function void check_result(pixel_t got);
    pixel_t want;
    pixels_seen++;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel beat: x=%0d y=%0d addr=%0d colour=%h paint=%0b done=%0b last=%0b",
                 got.x, got.y, got.addr, got.colour, got.paint, got.done, got.last);
      return;
    end
    want = pending_pixels.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("pixel mismatch, expected: x=%0d y=%0d addr=%0d colour=%h paint=%0b done=%0b last=%0b",
                 want.x, want.y, want.addr, want.colour, want.paint, want.done, want.last);
        $display("                   got: x=%0d y=%0d addr=%0d colour=%h paint=%0b done=%0b last=%0b",
                 got.x, got.y, got.addr, got.colour, got.paint, got.done, got.last);
      end
    end
  endfunction

  function int leftover();
    return pending_pixels.size();
  endfunction
endclass

module tb_top;
  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  op_t                        in_op;
  logic signed [COORD_W-1:0]  in_x_start;
  logic signed [COORD_W-1:0]  in_y_start;
  logic signed [COORD_W-1:0]  in_x_end;
  logic signed [COORD_W-1:0]  in_y_end;
  logic [COL_W-1:0]           in_pen_colour;
  style_t                     in_style;
  logic                       out_valid;
  logic                       out_stall;
  logic [PIX_W-1:0]           out_pix_x;
  logic [PIX_W-1:0]           out_pix_y;
  logic [ADDR_W-1:0]          out_pix_addr;
  logic [COL_W-1:0]           out_pix_colour;
  logic                       out_paint;
  logic                       out_line_done;
  logic                       out_last;
  logic                       cfg_we;
  cfg_idx_t                   cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  raster_board board;
  int starts_sent = 0;
  int steps_sent = 0;
  int surfaces_tried = 1;
  int burst_left = 0;

  clipped_line_rasterizer #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end),
    .in_pen_colour(in_pen_colour), .in_style(in_style),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pix_x(out_pix_x), .out_pix_y(out_pix_y), .out_pix_addr(out_pix_addr),
    .out_pix_colour(out_pix_colour), .out_paint(out_paint),
    .out_line_done(out_line_done), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(pixel_t'{x: out_pix_x, y: out_pix_y, addr: out_pix_addr,
                                  colour: out_pix_colour, paint: out_paint,
                                  done: out_line_done, last: out_last});
  end

  // receiver back-pressure: short stalls, a few long ones, some clear stretches
  initial begin
    int roll;
    int len;
    forever begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        out_stall <= 1'b0;
        len = $urandom_range(30, 120);
      end else if (roll < 15) begin
        out_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end else if (roll < 55) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 4);
      end
      repeat (len) @(posedge clk);
    end
  end

  function automatic int sender_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int fit12(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  task automatic send_beat(op_t op, logic signed [COORD_W-1:0] xs,
                           logic signed [COORD_W-1:0] ys, logic signed [COORD_W-1:0] xe,
                           logic signed [COORD_W-1:0] ye, logic [COL_W-1:0] pen, style_t sty);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_x_start    <= xs;
    in_y_start    <= ys;
    in_x_end      <= xe;
    in_y_end      <= ye;
    in_pen_colour <= pen;
    in_style      <= sty;
    do @(posedge clk); while (in_stall);
    if (op == OP_START) starts_sent++;
    else if (board.running) steps_sent++;
    board.note_input(op, xs, ys, xe, ye, pen, sty);
  endtask

  task automatic start_beat(int xs, int ys, int xe, int ye, logic [COL_W-1:0] pen, style_t sty);
    send_beat(OP_START, COORD_W'(xs), COORD_W'(ys), COORD_W'(xe), COORD_W'(ye), pen, sty);
  endtask

  // line fields are don't-care on a step, so they carry random junk
  task automatic step_beat();
    send_beat(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), COL_W'($urandom), style_t'($urandom));
  endtask

  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (board.leftover() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic set_surface(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SURFACE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_SURFACE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_surface(CFG_SURFACE_WIDTH, w);
    board.set_surface(CFG_SURFACE_HEIGHT, h);
    surfaces_tried++;
  endtask

  task automatic directed_lines();
    step_beat();
    start_beat(-2048, -2048, -2046, -2047, 16'h0000, STYLE_SOLID);
    repeat (3) step_beat();
    start_beat(2047, 2047, 2045, 2047, 16'hFFFF, STYLE_THICK);
    repeat (3) step_beat();
    start_beat(0, 0, 7, 3, 16'hA5A5, STYLE_DOTTED);
    repeat (8) step_beat();
    start_beat(2047, -2048, -2048, 2047, 16'h5A5A, STYLE_SPARE);
    step_beat();
    // abandons the long line, single point, then a stray step after done
    start_beat(10, 5, 10, 5, 16'h1234, STYLE_SOLID);
    repeat (2) step_beat();
  endtask

  task automatic random_lines(int budget);
    int used;
    int w;
    int h;
    int x0;
    int y0;
    int x1;
    int y1;
    int len;
    int steps;
    int k;
    int roll;
    logic acted;
    w = board.eff_dim(board.width_reg);
    h = board.eff_dim(board.height_reg);
    used = 0;
    while (used < budget) begin
      if (!board.running && $urandom_range(19) == 0) step_beat();
      roll = $urandom_range(99);
      if (roll < 12) begin
        x0 = int'($urandom_range(4095)) - 2048;
        y0 = int'($urandom_range(4095)) - 2048;
        x1 = int'($urandom_range(4095)) - 2048;
        y1 = int'($urandom_range(4095)) - 2048;
        steps = $urandom_range(1, 20);
      end else begin
        x0 = fit12(int'($urandom_range(w + 12)) - 6);
        y0 = fit12(int'($urandom_range(h + 12)) - 6);
        x1 = fit12(x0 + int'($urandom_range(24)) - 12);
        y1 = fit12(y0 + int'($urandom_range(24)) - 12);
        len = ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) len = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = len + 1;
        if (roll < 85) steps = len + (($urandom_range(9) == 0) ? 1 : 0);
        else steps = $urandom_range(len);
      end
      start_beat(x0, y0, x1, y1, COL_W'($urandom), style_t'($urandom_range(3)));
      used++;
      for (k = 0; k < steps; k++) begin
        acted = board.running;
        step_beat();
        if (acted) used++;
      end
    end
  endtask

  initial begin
    int surf_w[6];
    int surf_h[6];
    int i;
    surf_w = '{0, 4095, 2048, 1, 57, 1280};
    surf_h = '{0, 4095, 1, 2048, 23, 800};
    board = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_START;
    in_x_start    <= '0;
    in_y_start    <= '0;
    in_x_end      <= '0;
    in_y_end      <= '0;
    in_pen_colour <= '0;
    in_style      <= STYLE_SOLID;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SURFACE_WIDTH;
    cfg_wdata     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    directed_lines();
    random_lines(85);
    for (i = 0; i < 6; i++) begin
      settle();
      set_surface(CFG_W'(surf_w[i]), CFG_W'(surf_h[i]));
      random_lines(70);
    end
    settle();
    if (board.leftover() > 0) begin
      $display("%0d predicted pixel beats never arrived", board.leftover());
      board.mismatches += board.leftover();
    end
    $display("walked %0d lines with %0d live steps across %0d surface sizes",
             starts_sent, steps_sent, surfaces_tried);
    $display("checked %0d pixel beats, %0d mismatches", board.pixels_seen, board.mismatches);
    if (board.mismatches == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("run timed out");
    $display("tb_top: errors");
    $finish;
  end
endmodule
